/* design/mwm_pkg.sv */
package mwm_pkg;

	// Field widths of the channels and the configuration registers.
	localparam int EFFORT_BITS = 12;
	localparam int GAIN_BITS   = 16;
	localparam int LIMIT_BITS  = 11;
	localparam int OFFSET_BITS = 12;
	localparam int PULSE_BITS  = 12;
	localparam int CFG_BITS    = 16;

	// Internal widths. The rotation product is exact, the wheel powers keep two guard bits.
	localparam int PROD_BITS  = EFFORT_BITS + GAIN_BITS + 1;
	localparam int ROT_BITS   = EFFORT_BITS + 8;
	localparam int POWER_BITS = ROT_BITS + 2;
	localparam int MAG_BITS   = POWER_BITS;
	localparam int QUOT_BITS  = LIMIT_BITS;
	localparam int NUM_BITS   = MAG_BITS + LIMIT_BITS;

	localparam int WHEELS = 4;
	localparam int QUEUE_DEPTH = 4;

	// Register reset values.
	localparam logic [GAIN_BITS-1:0]   ROTATE_GAIN_RESET   = 16'd256;
	localparam logic [LIMIT_BITS-1:0]  POWER_LIMIT_RESET   = 11'd500;
	localparam logic [OFFSET_BITS-1:0] NEUTRAL_PULSE_RESET = 12'd1500;
	localparam logic [PULSE_BITS-1:0]  PULSE_MAX = 12'd4095;

	// Wheel order inside the power vectors.
	localparam int WHEEL_LF = 0;
	localparam int WHEEL_RF = 1;
	localparam int WHEEL_LR = 2;
	localparam int WHEEL_RR = 3;

	typedef enum logic [1:0] {
		REG_ROTATE_GAIN   = 2'd0,
		REG_POWER_LIMIT   = 2'd1,
		REG_NEUTRAL_PULSE = 2'd2
	} cfg_reg_t;

	typedef logic signed [POWER_BITS-1:0] power_t;
	typedef logic [MAG_BITS-1:0] mag_t;

	typedef struct packed {
		logic signed [EFFORT_BITS-1:0] x_effort;
		logic signed [EFFORT_BITS-1:0] y_effort;
		logic signed [EFFORT_BITS-1:0] rotate_effort;
	} mix_in_t;

	typedef struct packed {
		logic [PULSE_BITS-1:0] pulse_left_front;
		logic [PULSE_BITS-1:0] pulse_right_front;
		logic [PULSE_BITS-1:0] pulse_left_rear;
		logic [PULSE_BITS-1:0] pulse_right_rear;
		logic                  was_scaled;
	} mix_out_t;

	// One classified item as it travels from the front end to the back end.
	typedef struct packed {
		power_t [WHEELS-1:0] power;
		mag_t   [WHEELS-1:0] mag;
		mag_t                max_mag;
		logic                scaled;
	} mix_item_t;

endpackage

/* design/mecanum_wheel_mixer.sv */
// An input transfer passes through 5 front stages, the queue, a dividend stage,
// an 11-stage restoring divider, select and output before its result shows on out_valid.
// Throughput: one item per cycle if unstalled; divider lanes pipelined, one quotient bit a stage.
// A stalled output holds the back end while the front end keeps filling the queue.
// Reset (arst_n low, asynchronous) empties the pipelines and the queue and sets
// rotate_gain to 256, power_limit to 500 and the neutral pulse width to 1500.
module mecanum_wheel_mixer #(
	parameter int QUEUE_DEPTH = mwm_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  mwm_pkg::mix_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output mwm_pkg::mix_out_t              out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [mwm_pkg::CFG_BITS-1:0]   cfg_data
);

	logic [mwm_pkg::GAIN_BITS-1:0]   rotate_gain_q;
	logic [mwm_pkg::LIMIT_BITS-1:0]  power_limit_q;
	logic [mwm_pkg::OFFSET_BITS-1:0] neutral_pulse_q;

	logic               push_valid, push_ready, pop_valid, pop_ready;
	mwm_pkg::mix_item_t push_data, pop_data;

	// Configuration registers; writes to an unknown index are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotate_gain_q   <= mwm_pkg::ROTATE_GAIN_RESET;
			power_limit_q   <= mwm_pkg::POWER_LIMIT_RESET;
			neutral_pulse_q <= mwm_pkg::NEUTRAL_PULSE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				mwm_pkg::REG_ROTATE_GAIN: rotate_gain_q <= cfg_data[mwm_pkg::GAIN_BITS-1:0];
				mwm_pkg::REG_POWER_LIMIT: power_limit_q <= cfg_data[mwm_pkg::LIMIT_BITS-1:0];
				mwm_pkg::REG_NEUTRAL_PULSE: begin
					neutral_pulse_q <= cfg_data[mwm_pkg::OFFSET_BITS-1:0];
				end
				default: ;
			endcase
		end
	end

	mwm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.rotate_gain (rotate_gain_q),
		.power_limit (power_limit_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	mwm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mwm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_data      (pop_data),
		.power_limit   (power_limit_q),
		.neutral_pulse (neutral_pulse_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

endmodule

/* design/mwm_front.sv */
module mwm_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  mwm_pkg::mix_in_t                     in_data,
	input  logic [mwm_pkg::GAIN_BITS-1:0]        rotate_gain,
	input  logic [mwm_pkg::LIMIT_BITS-1:0]       power_limit,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output mwm_pkg::mix_item_t                   push_data
);

	localparam int E  = mwm_pkg::EFFORT_BITS;
	localparam int PB = mwm_pkg::PROD_BITS;
	localparam int RB = mwm_pkg::ROT_BITS;
	localparam int WB = mwm_pkg::POWER_BITS;
	localparam int MB = mwm_pkg::MAG_BITS;
	localparam int NW = mwm_pkg::WHEELS;

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic signed [E-1:0]  x_s1, y_s1, r_s1;
	logic signed [E-1:0]  x_s2, y_s2;
	logic signed [PB-1:0] prod_s2;
	mwm_pkg::power_t [NW-1:0] power_s3;
	mwm_pkg::power_t [NW-1:0] power_s4;
	mwm_pkg::mag_t   [NW-1:0] mag_s4;
	mwm_pkg::mix_item_t       item_s5;

	logic signed [PB-1:0] prod_biased;
	logic signed [RB-1:0] rot;
	logic signed [WB-1:0] x_ext, y_ext, r_ext;
	mwm_pkg::mag_t        max01, max23, max_all;

	// The whole front pipeline moves unless its last stage cannot hand off to the queue.
	assign adv        = !valid_s5 || push_ready;
	assign in_ready   = adv;
	assign push_valid = valid_s5;
	assign push_data  = item_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Rotation scaled by the Q8.8 gain, truncated toward zero.
	assign prod_biased = prod_s2 + $signed({{(PB-8){1'b0}}, {8{prod_s2[PB-1]}}});
	assign rot         = prod_biased[RB+7:8];
	assign x_ext       = WB'(x_s2);
	assign y_ext       = WB'(y_s2);
	assign r_ext       = WB'(rot);

	// Largest magnitude of the four wheels.
	assign max01   = (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];
	assign max23   = (mag_s4[2] > mag_s4[3]) ? mag_s4[2] : mag_s4[3];
	assign max_all = (max01 > max23) ? max01 : max23;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= in_data.x_effort;
			y_s1 <= in_data.y_effort;
			r_s1 <= in_data.rotate_effort;

			x_s2    <= x_s1;
			y_s2    <= y_s1;
			prod_s2 <= PB'(r_s1) * PB'($signed({1'b0, rotate_gain}));

			power_s3[mwm_pkg::WHEEL_LF] <= x_ext + y_ext + r_ext;
			power_s3[mwm_pkg::WHEEL_RF] <= x_ext - y_ext + r_ext;
			power_s3[mwm_pkg::WHEEL_LR] <= r_ext - x_ext + y_ext;
			power_s3[mwm_pkg::WHEEL_RR] <= r_ext - x_ext - y_ext;

			power_s4 <= power_s3;
			for (int w = 0; w < NW; w++) begin
				mag_s4[w] <= power_s3[w][WB-1] ? MB'($unsigned(-power_s3[w]))
				                               : MB'($unsigned(power_s3[w]));
			end

			item_s5.power   <= power_s4;
			item_s5.mag     <= mag_s4;
			item_s5.max_mag <= max_all;
			item_s5.scaled  <= max_all > MB'(power_limit);
		end
	end

endmodule

/* design/mwm_fifo.sv */
module mwm_fifo #(
	parameter int DEPTH = mwm_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  mwm_pkg::mix_item_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output mwm_pkg::mix_item_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mwm_pkg::mix_item_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count exceeds its depth");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && count_q == '0 |=> pop_valid)
		else $error("transfer into an empty queue did not appear at its head");

endmodule

/* design/mwm_div.sv */
module mwm_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [mwm_pkg::NUM_BITS-1:0]    num,
	input  logic [mwm_pkg::MAG_BITS-1:0]    den,
	output logic [mwm_pkg::QUOT_BITS-1:0]   quot
);

	localparam int Q  = mwm_pkg::QUOT_BITS;
	localparam int NB = mwm_pkg::NUM_BITS;
	localparam int MB = mwm_pkg::MAG_BITS;

	// Restoring division, one quotient bit per stage, most significant first.
	// The quotient is known to fit in Q bits whenever it is used.
	logic [NB-1:0] rem_s  [Q];
	logic [MB-1:0] den_s  [Q];
	logic [Q-1:0]  quot_s [Q];

	for (genvar k = 0; k < Q; k++) begin : g_stage
		localparam int B = Q - 1 - k;
		logic [NB-1:0] rem_in, trial;
		logic [MB-1:0] den_in;
		logic [Q-1:0]  quot_in;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in  = num;
			assign den_in  = den;
			assign quot_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign quot_in = quot_s[k-1];
		end

		assign trial = NB'(den_in) << B;
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_in - trial : rem_in;
				den_s[k]  <= den_in;
				quot_s[k] <= quot_in | (Q'(ge) << B);
			end
		end
	end

	assign quot = quot_s[Q-1];

endmodule

/* design/mwm_back.sv */
module mwm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pop_valid,
	output logic                              pop_ready,
	input  mwm_pkg::mix_item_t                pop_data,
	input  logic [mwm_pkg::LIMIT_BITS-1:0]    power_limit,
	input  logic [mwm_pkg::OFFSET_BITS-1:0]   neutral_pulse,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mwm_pkg::mix_out_t                 out_data
);

	localparam int Q  = mwm_pkg::QUOT_BITS;
	localparam int NB = mwm_pkg::NUM_BITS;
	localparam int WB = mwm_pkg::POWER_BITS;
	localparam int PW = mwm_pkg::PULSE_BITS;
	localparam int NW = mwm_pkg::WHEELS;

	typedef struct packed {
		mwm_pkg::power_t [NW-1:0] power;
		logic                     scaled;
	} side_t;

	logic adv;
	// Stage 0 forms the dividend, stages 1..Q divide, stage Q+1 picks the wheel power.
	logic [Q+1:0] vld_s;
	side_t        side_s [Q+1];
	logic [NB-1:0]             num_s1 [NW];
	mwm_pkg::mag_t             den_s1;
	logic [Q-1:0]              quot   [NW];
	mwm_pkg::power_t [NW-1:0]  power_sel_s;
	logic                      scaled_sel_s;

	logic              out_valid_q;
	mwm_pkg::mix_out_t out_data_q;
	logic [PW-1:0]     pulse [NW];

	assign adv       = !out_valid_q || out_ready;
	assign pop_ready = adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s       <= {vld_s[Q:0], pop_valid};
			out_valid_q <= vld_s[Q+1];
		end
	end

	// Dividend is the wheel magnitude times the limit; divisor is the largest magnitude.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int w = 0; w < NW; w++) begin
				num_s1[w] <= NB'(pop_data.mag[w]) * NB'(power_limit);
			end
			den_s1           <= pop_data.max_mag;
			side_s[0].power  <= pop_data.power;
			side_s[0].scaled <= pop_data.scaled;
			for (int k = 1; k <= Q; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	for (genvar w = 0; w < NW; w++) begin : g_lane
		mwm_div u_div (
			.clk  (clk),
			.en   (adv),
			.num  (num_s1[w]),
			.den  (den_s1),
			.quot (quot[w])
		);
	end

	// Restore the sign of a scaled power, or keep the power as mixed.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int w = 0; w < NW; w++) begin
				if (!side_s[Q].scaled) begin
					power_sel_s[w] <= side_s[Q].power[w];
				end else if (side_s[Q].power[w][WB-1]) begin
					power_sel_s[w] <= -WB'($signed({1'b0, quot[w]}));
				end else begin
					power_sel_s[w] <= WB'($signed({1'b0, quot[w]}));
				end
			end
			scaled_sel_s <= side_s[Q].scaled;
		end
	end

	// Add the neutral pulse width and clamp to the pulse range.
	always_comb begin
		logic signed [WB:0] sum;
		for (int w = 0; w < NW; w++) begin
			sum = (WB+1)'($signed({1'b0, neutral_pulse})) + (WB+1)'($signed(power_sel_s[w]));
			if (sum[WB]) begin
				pulse[w] = '0;
			end else if (sum > (WB+1)'($signed({1'b0, mwm_pkg::PULSE_MAX}))) begin
				pulse[w] = mwm_pkg::PULSE_MAX;
			end else begin
				pulse[w] = sum[PW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.pulse_left_front  <= pulse[mwm_pkg::WHEEL_LF];
			out_data_q.pulse_right_front <= pulse[mwm_pkg::WHEEL_RF];
			out_data_q.pulse_left_rear   <= pulse[mwm_pkg::WHEEL_LR];
			out_data_q.pulse_right_rear  <= pulse[mwm_pkg::WHEEL_RR];
			out_data_q.was_scaled        <= scaled_sel_s;
		end
	end

	a_quot_limit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[Q] && side_s[Q].scaled |->
			Q'(power_limit) >= quot[0] && Q'(power_limit) >= quot[1] &&
			Q'(power_limit) >= quot[2] && Q'(power_limit) >= quot[3])
		else $error("scaled wheel power exceeds the power limit");

	a_unscaled_pass: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[Q] && !side_s[Q].scaled |=> power_sel_s == $past(side_s[Q].power))
		else $error("unscaled item did not keep its mixed powers");

endmodule

/* verif/mix_checker.sv */
module mix_checker
	import mwm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  mix_in_t             in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  mix_out_t            out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	output int                  errors,
	output int                  outstanding
);

	// Local copy of the configuration registers.
	logic [GAIN_BITS-1:0]   gain_q   = ROTATE_GAIN_RESET;
	logic [LIMIT_BITS-1:0]  limit_q  = POWER_LIMIT_RESET;
	logic [OFFSET_BITS-1:0] offset_q = NEUTRAL_PULSE_RESET;

	// Pulse sets still owed by the block, oldest first.
	mix_out_t pending_pulses[$];
	mix_out_t want;
	int       err_count = 0;
	int       open_count = 0;
	int       bad;

	assign errors      = err_count;
	assign outstanding = open_count;

	// Offset a wheel power and clamp it to the servo pulse range.
	function automatic logic [PULSE_BITS-1:0] to_pulse(input longint power);
		longint s;
		s = longint'(offset_q) + power;
		if (s < 0)
			s = 0;
		if (s > longint'(PULSE_MAX))
			s = longint'(PULSE_MAX);
		return s[PULSE_BITS-1:0];
	endfunction

	// Mix the three efforts into four wheel pulses, scaling down when the
	// largest wheel magnitude is above the power limit.
	function automatic mix_out_t mix_wheels(input mix_in_t d);
		longint   x, y, r, rot, lim, peak, m;
		longint   p[WHEELS];
		mix_out_t o;
		x   = $signed(d.x_effort);
		y   = $signed(d.y_effort);
		r   = $signed(d.rotate_effort);
		rot = (r * longint'(gain_q)) / 256;
		lim = longint'(limit_q);
		p[WHEEL_LF] = x + y + rot;
		p[WHEEL_RF] = x - y + rot;
		p[WHEEL_LR] = -x + y + rot;
		p[WHEEL_RR] = -x - y + rot;
		peak = 0;
		for (int i = 0; i < WHEELS; i++) begin
			m = (p[i] < 0) ? -p[i] : p[i];
			if (m > peak)
				peak = m;
		end
		o.was_scaled = (peak > lim);
		if (o.was_scaled) begin
			for (int i = 0; i < WHEELS; i++)
				p[i] = (p[i] * lim) / peak;
		end
		o.pulse_left_front  = to_pulse(p[WHEEL_LF]);
		o.pulse_right_front = to_pulse(p[WHEEL_RF]);
		o.pulse_left_rear   = to_pulse(p[WHEEL_LR]);
		o.pulse_right_rear  = to_pulse(p[WHEEL_RR]);
		return o;
	endfunction

	function automatic int field_diff(input string label, input logic [PULSE_BITS-1:0] exp_v,
			input logic [PULSE_BITS-1:0] act_v);
		if (act_v === exp_v)
			return 0;
		$display("%0t: %s expected %0d, got %0d", $time, label, exp_v, act_v);
		return 1;
	endfunction

	// Track register writes, predict on each input transfer and compare on each
	// output transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= ROTATE_GAIN_RESET;
			limit_q  <= POWER_LIMIT_RESET;
			offset_q <= NEUTRAL_PULSE_RESET;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROTATE_GAIN: gain_q <= cfg_data[GAIN_BITS-1:0];
					REG_POWER_LIMIT: limit_q <= cfg_data[LIMIT_BITS-1:0];
					REG_NEUTRAL_PULSE: offset_q <= cfg_data[OFFSET_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pending_pulses.push_back(mix_wheels(in_data));
			if (out_valid && out_ready) begin
				if (pending_pulses.size() == 0) begin
					$display("%0t: result with nothing expected, got %h", $time, out_data);
					bad++;
				end else begin
					want = pending_pulses.pop_front();
					bad += field_diff("pulse_left_front", want.pulse_left_front,
						out_data.pulse_left_front);
					bad += field_diff("pulse_right_front", want.pulse_right_front,
						out_data.pulse_right_front);
					bad += field_diff("pulse_left_rear", want.pulse_left_rear,
						out_data.pulse_left_rear);
					bad += field_diff("pulse_right_rear", want.pulse_right_rear,
						out_data.pulse_right_rear);
					bad += field_diff("was_scaled", PULSE_BITS'(want.was_scaled),
						PULSE_BITS'(out_data.was_scaled));
				end
			end
			err_count  <= err_count + bad;
			open_count <= pending_pulses.size();
		end
	end

endmodule

/* verif/tb_top.sv */
module tb_top;
	import mwm_pkg::*;

	localparam int RANDOM_ITEMS  = 400;
	localparam int PHASES        = 5;
	localparam int SETTLE_CYCLES = 40;
	// Index past the register list; writes to it must be ignored.
	localparam logic [1:0] REG_NONE = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	mix_in_t             in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	mix_out_t            out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;
	int                  errors;
	int                  outstanding;
	bit                  steady = 1'b0;

	mecanum_wheel_mixer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mix_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Gap before an input transfer: mostly none or short, now and then long.
	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Effort values: full range, near zero, or one of the extremes, zero or minus one.
	function automatic logic [EFFORT_BITS-1:0] rand_effort();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			return EFFORT_BITS'($urandom_range(0, 4095));
		if (roll < 7)
			return EFFORT_BITS'($urandom_range(0, 400) - 200);
		if (roll < 9)
			return EFFORT_BITS'($urandom_range(0, 40) - 20);
		case ($urandom_range(0, 3))
			0: return 12'h7FF;
			1: return 12'h800;
			2: return 12'h000;
			default: return 12'hFFF;
		endcase
	endfunction

	// One input transfer; valid stays high afterwards so that a back-to-back
	// item does not lower and raise it within one step.
	task automatic send_mix(input logic [EFFORT_BITS-1:0] x, input logic [EFFORT_BITS-1:0] y,
			input logic [EFFORT_BITS-1:0] r, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= '{x_effort: x, y_effort: y, rotate_effort: r};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_regs(input logic [CFG_BITS-1:0] gain, input logic [CFG_BITS-1:0] limit,
			input logic [CFG_BITS-1:0] offset);
		write_reg(REG_ROTATE_GAIN, gain);
		write_reg(REG_POWER_LIMIT, limit);
		write_reg(REG_NEUTRAL_PULSE, offset);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait until every result is back and the pipe is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: ready in runs, with short and occasional long stalls.
	initial begin
		int run, stall, roll;
		@(posedge arst_n);
		forever begin
			roll  = $urandom_range(0, 99);
			run   = (roll < 10) ? $urandom_range(50, 200) : $urandom_range(1, 8);
			stall = (roll < 10) ? 0 : ((roll < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60));
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: field extremes, each axis alone, all at once.
		send_mix(12'h000, 12'h000, 12'h000, 0);
		send_mix(12'h7FF, 12'h000, 12'h000, gap_len());
		send_mix(12'h800, 12'h000, 12'h000, gap_len());
		send_mix(12'h000, 12'h7FF, 12'h000, gap_len());
		send_mix(12'h000, 12'h800, 12'h000, gap_len());
		send_mix(12'h000, 12'h000, 12'h7FF, gap_len());
		send_mix(12'h000, 12'h000, 12'h800, gap_len());
		send_mix(12'h7FF, 12'h7FF, 12'h7FF, gap_len());
		send_mix(12'h800, 12'h800, 12'h800, gap_len());
		send_mix(12'd100, 12'hFCE, 12'd25, gap_len());
		send_mix(12'hFFF, 12'hFFF, 12'hFFF, gap_len());

		// Largest gain, limit and offset: pulses clamp at the top.
		settle();
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_mix(12'h000, 12'h000, 12'h7FF, gap_len());
		send_mix(12'h800, 12'h7FF, 12'h800, gap_len());
		send_mix(12'h000, 12'h000, 12'h000, gap_len());

		// Zero limit, zero gain, zero offset: any nonzero power scales to nothing.
		settle();
		set_regs(16'h0000, 16'h0000, 16'h0000);
		send_mix(12'h7FF, 12'h800, 12'h7FF, gap_len());
		send_mix(12'h000, 12'h000, 12'h7FF, gap_len());
		send_mix(12'd3, 12'h000, 12'h000, gap_len());

		// Tiny gain truncates rotation toward zero; negative powers clamp at zero.
		settle();
		set_regs(16'd1, 16'd2047, 16'd0);
		send_mix(12'h800, 12'h000, 12'hFFF, gap_len());
		send_mix(12'hF9C, 12'd50, 12'h801, gap_len());

		// A write past the register list leaves the configuration alone.
		settle();
		write_reg(REG_NONE, 16'hFFFF);
		cfg_valid <= 1'b0;
		send_mix(12'd10, 12'd20, 12'd30, gap_len());

		// Random items in phases, each phase with its own configuration.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: set_regs(16'd256, 16'd500, 16'd1500);
				1: begin
					write_reg(REG_NONE, CFG_BITS'($urandom));
					set_regs(CFG_BITS'($urandom), CFG_BITS'($urandom), CFG_BITS'($urandom));
				end
				2: set_regs(CFG_BITS'($urandom_range(0, 1023)), CFG_BITS'($urandom_range(1, 2047)),
					CFG_BITS'($urandom_range(0, 4095)));
				3: set_regs(16'hFFFF, 16'd1, 16'd0);
				default: set_regs(16'h0180, CFG_BITS'($urandom_range(0, 2047)), 16'd2048);
			endcase
			for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
				if (k % 20 == 0)
					steady = ($urandom_range(0, 3) == 0);
				send_mix(rand_effort(), rand_effort(), rand_effort(), gap_len());
			end
			steady = 1'b0;
		end

		settle();
		if (errors == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* mecanum_wheel_mixer.f */
design/mwm_pkg.sv
design/mwm_front.sv
design/mwm_fifo.sv
design/mwm_div.sv
design/mwm_back.sv
design/mecanum_wheel_mixer.sv
verif/mix_checker.sv
verif/tb_top.sv
